@@ sv/v3n_pkg.sv @@
// Package for the 3D vector normalizer: widths, stage data types and the
// per-stage square root and division steps.
// No dependencies.
package v3n_pkg;

    localparam int CoordWidth    = 24;
    localparam int NumComp       = 3;
    localparam int SqWidth       = 2 * CoordWidth;
    localparam int QuoWidth      = CoordWidth - 1;
    localparam int SqrtRemWidth  = CoordWidth + 2;
    localparam int InDataWidth   = ((NumComp * CoordWidth + 7) / 8) * 8;
    localparam int OutFieldWidth = SqWidth + (1 + NumComp) * CoordWidth;
    localparam int OutDataWidth  = ((OutFieldWidth + 7) / 8) * 8;

    // Field offsets in the result tdata, lowest bit first
    localparam int SqLsb    = 0;
    localparam int NormLsb  = SqWidth;
    localparam int UnitXLsb = SqWidth + CoordWidth;
    localparam int UnitYLsb = SqWidth + 2 * CoordWidth;
    localparam int UnitZLsb = SqWidth + 3 * CoordWidth;

    typedef logic [CoordWidth-1:0] coord_t;
    typedef logic [SqWidth-1:0]    sq_t;

    // Component magnitudes and signs
    typedef struct packed {
        logic [NumComp-1:0][CoordWidth-1:0] mag;
        logic [NumComp-1:0]                 neg;
    } comp_t;

    // One square root stage: radicand bits still to use, partial remainder and root
    typedef struct packed {
        comp_t                   comp;
        sq_t                     sq;
        sq_t                     rad;
        logic [SqrtRemWidth-1:0] rem;
        coord_t                  root;
    } sqrt_t;

    // One division stage, three dividers side by side sharing the divisor
    typedef struct packed {
        sq_t                                sq;
        coord_t                             nrm;
        logic [NumComp-1:0]                 neg;
        logic [NumComp-1:0]                 low;
        logic [NumComp-1:0][CoordWidth-1:0] rem;
        logic [NumComp-1:0][QuoWidth-1:0]   quo;
    } div_t;

    // Produce one root bit: try subtracting (4*root + 1) from the shifted remainder
    function automatic sqrt_t sqrt_step(sqrt_t cur);
        sqrt_t                   nxt;
        logic [SqrtRemWidth+1:0] trial;
        logic [SqrtRemWidth+1:0] sub;
        logic [SqrtRemWidth+1:0] diff;
        nxt   = cur;
        trial = {cur.rem, cur.rad[SqWidth-1 -: 2]};
        sub   = {2'b00, cur.root, 2'b01};
        diff  = trial - sub;
        nxt.rad = {cur.rad[SqWidth-3:0], 2'b00};
        if (trial >= sub) begin
            nxt.rem  = diff[SqrtRemWidth-1:0];
            nxt.root = {cur.root[CoordWidth-2:0], 1'b1};
        end else begin
            nxt.rem  = trial[SqrtRemWidth-1:0];
            nxt.root = {cur.root[CoordWidth-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Produce one quotient bit per component (restoring long division)
    function automatic div_t div_step(div_t cur);
        div_t                nxt;
        logic [CoordWidth:0] trial;
        logic [CoordWidth:0] dvs;
        logic [CoordWidth:0] diff;
        nxt = cur;
        dvs = {1'b0, cur.nrm};
        for (int c = 0; c < NumComp; c++) begin
            trial = {cur.rem[c], cur.low[c]};
            diff  = trial - dvs;
            if (trial >= dvs) begin
                nxt.rem[c] = diff[CoordWidth-1:0];
                nxt.quo[c] = {cur.quo[c][QuoWidth-2:0], 1'b1};
            end else begin
                nxt.rem[c] = trial[CoordWidth-1:0];
                nxt.quo[c] = {cur.quo[c][QuoWidth-2:0], 1'b0};
            end
        end
        // Only the first step brings in a dividend bit; the rest are zeros
        nxt.low = '0;
        return nxt;
    endfunction

endpackage

@@ sv/vector3_normalize_core.sv @@
// Channel   | dir | tdata fields (lowest bit up)                          | tuser
// s_axis    | in  | x_in, y_in, z_in (24 b signed each)                   | -
// m_axis    | out | squared_norm 48 b, norm 24 b, unit_x, unit_y, unit_z  | zero_vector
//
// One vector enters per cycle unless m_axis stalls; each result passes through
// these stages in order: input, square, sum, one stage per root bit and
// one stage per quotient bit of the three dividers, output register.
// aresetn clears the valid bits only; no state survives between vectors.
// A stall at m_axis freezes every stage at once; s_axis_tready is low then.
//
// 3D vector normalizer top level. Depends on v3n_pkg.
module vector3_normalize_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [v3n_pkg::InDataWidth-1:0]  s_axis_tdata,  // x_in, y_in, z_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [v3n_pkg::OutDataWidth-1:0] m_axis_tdata,  // squared_norm, norm,
                                                            // unit_x, unit_y, unit_z
    output logic [0:0]                     m_axis_tuser     // zero_vector
);
    import v3n_pkg::*;

    localparam int NumStages = 3 + CoordWidth + QuoWidth + 1;

    logic [NumStages-1:0]               valid_reg;
    logic                               advance;
    comp_t                              in_next;
    comp_t                              in_reg;
    comp_t                              comp1_reg;
    comp_t                              comp2_reg;
    logic [NumComp-1:0][SqWidth-1:0]    prod_reg;
    sq_t                                sum_reg;
    sqrt_t                              sqrt_init_next;
    sqrt_t                              sqrt_reg [CoordWidth];
    div_t                               div_init_next;
    div_t                               div_reg [QuoWidth];
    sq_t                                sq_out_reg;
    coord_t                             norm_out_reg;
    logic [NumComp-1:0][CoordWidth-1:0] unit_next;
    logic [NumComp-1:0][CoordWidth-1:0] unit_out_reg;
    logic                               zero_next;
    logic                               zero_out_reg;

    // Advance the whole pipeline unless the output holds an untaken result
    assign advance       = !valid_reg[NumStages-1] || m_axis_tready;
    assign s_axis_tready = advance;

    // Shift valid bits along with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[NumStages-2:0], s_axis_tvalid};
        end
    end

    // Split each component into magnitude and sign
    always_comb begin
        for (int c = 0; c < NumComp; c++) begin
            in_next.neg[c] = s_axis_tdata[c*CoordWidth + CoordWidth - 1];
            if (in_next.neg[c]) begin
                in_next.mag[c] = ~s_axis_tdata[c*CoordWidth +: CoordWidth] + 1'b1;
            end else begin
                in_next.mag[c] = s_axis_tdata[c*CoordWidth +: CoordWidth];
            end
        end
    end

    // Register input, square, sum
    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg    <= in_next;
            comp1_reg <= in_reg;
            for (int c = 0; c < NumComp; c++) begin
                prod_reg[c] <= SqWidth'(in_reg.mag[c]) * SqWidth'(in_reg.mag[c]);
            end
            comp2_reg <= comp1_reg;
            sum_reg   <= prod_reg[0] + prod_reg[1] + prod_reg[2];
        end
    end

    // Seed the square root with the squared norm
    always_comb begin
        sqrt_init_next.comp = comp2_reg;
        sqrt_init_next.sq   = sum_reg;
        sqrt_init_next.rad  = sum_reg;
        sqrt_init_next.rem  = '0;
        sqrt_init_next.root = '0;
    end

    // Square root, one root bit per stage
    always_ff @(posedge aclk) begin
        if (advance) begin
            sqrt_reg[0] <= sqrt_step(sqrt_init_next);
            for (int k = 1; k < CoordWidth; k++) begin
                sqrt_reg[k] <= sqrt_step(sqrt_reg[k-1]);
            end
        end
    end

    // Seed the dividers: magnitude shifted up by the unit fraction, top part preloaded
    always_comb begin
        div_init_next.sq  = sqrt_reg[CoordWidth-1].sq;
        div_init_next.nrm = sqrt_reg[CoordWidth-1].root;
        div_init_next.neg = sqrt_reg[CoordWidth-1].comp.neg;
        for (int c = 0; c < NumComp; c++) begin
            div_init_next.low[c] = sqrt_reg[CoordWidth-1].comp.mag[c][0];
            div_init_next.rem[c] = sqrt_reg[CoordWidth-1].comp.mag[c] >> 1;
            div_init_next.quo[c] = '0;
        end
    end

    // Division, one quotient bit per stage for all three components
    always_ff @(posedge aclk) begin
        if (advance) begin
            div_reg[0] <= div_step(div_init_next);
            for (int j = 1; j < QuoWidth; j++) begin
                div_reg[j] <= div_step(div_reg[j-1]);
            end
        end
    end

    // Restore signs and drop the quotients of a zero vector
    always_comb begin
        zero_next = (div_reg[QuoWidth-1].sq == '0);
        for (int c = 0; c < NumComp; c++) begin
            if (zero_next) begin
                unit_next[c] = '0;
            end else if (div_reg[QuoWidth-1].neg[c]) begin
                unit_next[c] = ~{1'b0, div_reg[QuoWidth-1].quo[c]} + 1'b1;
            end else begin
                unit_next[c] = {1'b0, div_reg[QuoWidth-1].quo[c]};
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_out_reg   <= div_reg[QuoWidth-1].sq;
            norm_out_reg <= div_reg[QuoWidth-1].nrm;
            unit_out_reg <= unit_next;
            zero_out_reg <= zero_next;
        end
    end

    assign m_axis_tvalid = valid_reg[NumStages-1];
    assign m_axis_tdata  = OutDataWidth'({unit_out_reg[2], unit_out_reg[1], unit_out_reg[0],
                                          norm_out_reg, sq_out_reg});
    assign m_axis_tuser  = zero_out_reg;

endmodule

@@ sv/v3n_checker.sv @@
// Port-level checks for the 3D vector normalizer, bound to its top level.
// Depends on v3n_pkg and vector3_normalize_core.
module v3n_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [v3n_pkg::InDataWidth-1:0]  s_axis_tdata,  // x_in, y_in, z_in
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [v3n_pkg::OutDataWidth-1:0] m_axis_tdata,  // squared_norm, norm,
                                                           // unit_x, unit_y, unit_z
    input logic [0:0]                     m_axis_tuser     // zero_vector
);
    import v3n_pkg::*;

    logic [SqWidth-1:0]    sq_w;
    logic [CoordWidth-1:0] norm_w;
    logic [CoordWidth-1:0] ux_w;
    logic [CoordWidth-1:0] uy_w;
    logic [CoordWidth-1:0] uz_w;

    assign sq_w   = m_axis_tdata[SqLsb +: SqWidth];
    assign norm_w = m_axis_tdata[NormLsb +: CoordWidth];
    assign ux_w   = m_axis_tdata[UnitXLsb +: CoordWidth];
    assign uy_w   = m_axis_tdata[UnitYLsb +: CoordWidth];
    assign uz_w   = m_axis_tdata[UnitZLsb +: CoordWidth];

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A stalled output blocks new requests
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while output stalled");

    // Zero vector: zero squared norm, zero norm and zero unit components
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            sq_w == '0 && norm_w == '0 && ux_w == '0 && uy_w == '0 && uz_w == '0)
        else $error("zero vector with nonzero fields");

    // Any other vector has a nonzero norm
    a_norm_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> sq_w != '0 && norm_w != '0)
        else $error("nonzero vector with zero norm");

endmodule

bind vector3_normalize_core v3n_checker u_v3n_checker (.*);
